/* rtl/wdt_pkg.sv */
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and constants for the byte-wide register-mapped watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wdt_pkg;

  // Width of the preset and remaining tick counts (8 to 32).
  localparam int COUNT_WIDTH = 24;
  // Width of the word in which the preset bytes are assembled.
  localparam int PRESET_WORD = 32;

  // Commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register offsets
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_SIGSEL  = 3'd1;
  localparam logic [2:0] REG_PRESET0 = 3'd2;
  localparam logic [2:0] REG_PRESET1 = 3'd3;
  localparam logic [2:0] REG_PRESET2 = 3'd4;
  localparam logic [2:0] REG_STATUS  = 3'd5;
  localparam logic [2:0] REG_RELOAD  = 3'd6;

  // Register bits
  localparam int CTRL_ENABLE_BIT = 6;
  localparam int STAT_TIMEOUT_BIT = 7;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
  } wdt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timeout_seen;
    logic       fire;
    logic [3:0] fire_signal;
  } wdt_out_t;

endpackage

/* rtl/wdt_core.sv */
// ----------------------------------------------------------------------------
// wdt_core
// Register file, tick down-counter and expiry logic; one transaction a cycle while accept is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdt_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  wdt_pkg::wdt_in_t item,
  output wdt_pkg::wdt_out_t result
);

  logic [7:0]                       ctrl_r, ctrl_nxt;
  logic [7:0]                       sigsel_r, sigsel_nxt;
  logic [wdt_pkg::COUNT_WIDTH-1:0]  preset_r, preset_nxt;
  logic [wdt_pkg::COUNT_WIDTH-1:0]  remain_r, remain_nxt;
  logic                             flag_r, flag_nxt;

  logic [wdt_pkg::PRESET_WORD-1:0]  preset_ext;
  logic [wdt_pkg::PRESET_WORD-1:0]  data_ext;
  logic [wdt_pkg::PRESET_WORD-1:0]  preset_wr;
  logic                             enabled;

  assign preset_ext = wdt_pkg::PRESET_WORD'(preset_r);
  assign data_ext   = wdt_pkg::PRESET_WORD'(item.write_data);
  assign enabled    = ctrl_r[wdt_pkg::CTRL_ENABLE_BIT];

  // Byte insertion into the preset; bits above the count width drop out below.
  always_comb begin
    unique case (item.reg_offset)
      wdt_pkg::REG_PRESET0: preset_wr = (preset_ext & ~32'h0000_00ff) | data_ext;
      wdt_pkg::REG_PRESET1: preset_wr = (preset_ext & ~32'h0000_ff00) | (data_ext << 8);
      wdt_pkg::REG_PRESET2: preset_wr = (preset_ext & ~32'h00ff_0000) | (data_ext << 16);
      default:              preset_wr = preset_ext;
    endcase
  end

  always_comb begin
    ctrl_nxt   = ctrl_r;
    sigsel_nxt = sigsel_r;
    preset_nxt = preset_r;
    remain_nxt = remain_r;
    flag_nxt   = flag_r;
    result     = '0;

    unique case (item.command)
      wdt_pkg::CMD_READ: begin
        unique case (item.reg_offset)
          wdt_pkg::REG_CTRL:    result.read_data = ctrl_r;
          wdt_pkg::REG_SIGSEL:  result.read_data = sigsel_r;
          wdt_pkg::REG_PRESET0: result.read_data = preset_ext[7:0];
          wdt_pkg::REG_PRESET1: result.read_data = preset_ext[15:8];
          wdt_pkg::REG_PRESET2: result.read_data = preset_ext[23:16];
          wdt_pkg::REG_STATUS:  result.read_data = {flag_r, 7'd0};
          default:              result.read_data = 8'd0;
        endcase
      end
      wdt_pkg::CMD_WRITE: begin
        unique case (item.reg_offset)
          wdt_pkg::REG_CTRL: begin
            // rising enable restarts the count
            if (!enabled && item.write_data[wdt_pkg::CTRL_ENABLE_BIT]) begin
              remain_nxt = preset_r;
            end
            ctrl_nxt = item.write_data;
          end
          wdt_pkg::REG_SIGSEL: sigsel_nxt = item.write_data;
          wdt_pkg::REG_PRESET0,
          wdt_pkg::REG_PRESET1,
          wdt_pkg::REG_PRESET2: preset_nxt = preset_wr[wdt_pkg::COUNT_WIDTH-1:0];
          wdt_pkg::REG_STATUS: begin
            if (item.write_data[wdt_pkg::STAT_TIMEOUT_BIT]) begin
              flag_nxt = 1'b0;
            end
          end
          wdt_pkg::REG_RELOAD: remain_nxt = preset_r;
          default: ;
        endcase
      end
      wdt_pkg::CMD_TICK: begin
        if (enabled) begin
          if (remain_r <= wdt_pkg::COUNT_WIDTH'(1)) begin
            flag_nxt           = 1'b1;
            result.fire        = 1'b1;
            result.fire_signal = sigsel_r[7:4];
            remain_nxt         = preset_r;
          end else begin
            remain_nxt = remain_r - wdt_pkg::COUNT_WIDTH'(1);
          end
        end
      end
      default: ;
    endcase

    result.timeout_seen = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      sigsel_r <= '0;
      preset_r <= '0;
      remain_r <= '0;
      flag_r   <= 1'b0;
    end else if (accept) begin
      ctrl_r   <= ctrl_nxt;
      sigsel_r <= sigsel_nxt;
      preset_r <= preset_nxt;
      remain_r <= remain_nxt;
      flag_r   <= flag_nxt;
    end
  end

endmodule

/* rtl/wdt_obuf.sv */
// ----------------------------------------------------------------------------
// wdt_obuf
// Result register with a skid stage, so input is taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdt_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wdt_pkg::wdt_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output wdt_pkg::wdt_out_t out_data
);

  logic              out_valid_r;
  wdt_pkg::wdt_out_t out_data_r;
  logic              skid_valid_r;
  wdt_pkg::wdt_out_t skid_data_r;
  logic              slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      // push never coincides with a full skid stage
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/watchdog_timer_registers_core.sv */
// ----------------------------------------------------------------------------
// watchdog_timer_registers_core
// Byte-wide register-mapped watchdog with a tick-driven down-counter.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one transaction per item: a register read, a
//   register write or one timer tick. Every accepted transaction yields
//   exactly one result on the out_ channel: read data (zero unless a read),
//   the current timeout flag, and a fire pulse with the selected action
//   nibble when a tick made the watchdog expire.
//   The register update and the result are formed combinationally in the
//   cycle of acceptance; the result is captured by the output register,
//   or by the skid stage while the output stalls. Throughput is one
//   transaction per cycle while in_stall is low, with a 24-bit decrement.
//   When the receiver stalls, one further result is caught in a skid stage;
//   in_stall then rises until the output register drains.
//   Synchronous reset (rst_n low) disables the watchdog, clears all
//   registers and the timeout flag, and empties the output stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module watchdog_timer_registers_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wdt_pkg::wdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wdt_pkg::wdt_out_t out_data
);

  logic              accept;
  wdt_pkg::wdt_out_t result;

  assign accept = in_valid && !in_stall;

  wdt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (result)
  );

  wdt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
